### rtl/swsd_pkg.sv
// Shared widths, register indexes and constants for the sliding window stillness detector.
package swsd_pkg;

    localparam int unsigned DT_W    = 20;
    localparam int unsigned POS_W   = 24;
    localparam int unsigned TWIN_W  = 24;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned PPM_W   = 16;
    localparam int unsigned DIFF_W  = POS_W + 1;
    localparam int unsigned SQ_W    = 2 * DIFF_W;
    localparam int unsigned ROOT_W  = DIFF_W;
    localparam int unsigned QUO_W   = ROOT_W + 16;
    localparam int unsigned TSUM_W  = TWIN_W + 1;
    localparam int unsigned PADDR_W = 4;

    localparam logic [PPM_W-1:0]  PPM_ONE      = PPM_W'(1);
    localparam logic [TWIN_W-1:0] TWIN_RESET   = TWIN_W'(500000);
    localparam logic [DIST_W-1:0] DLIM_RESET   = DIST_W'(655);
    localparam logic [PPM_W-1:0]  PPM_RESET    = PPM_W'(8192);

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        REG_TIME_WINDOW = 2'd0,
        REG_DIST_LIMIT  = 2'd1,
        REG_PIX_PER_M   = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

endpackage

### rtl/swsd_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface swsd_in_if import swsd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [DT_W-1:0]         delta_time_us;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, command, delta_time_us, pos_x, pos_y, input ready);
    modport sink   (input valid, command, delta_time_us, pos_x, pos_y, output ready);
endinterface

interface swsd_out_if import swsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              stopped;
    logic              window_filled;
    logic [DIST_W-1:0] window_distance;
    logic [TWIN_W-1:0] window_time_us;

    modport source (output valid, stopped, window_filled, window_distance, window_time_us,
                    input ready);
    modport sink   (input valid, stopped, window_filled, window_distance, window_time_us,
                    output ready);
endinterface

### rtl/sliding_window_stillness_detector.sv
// Top level of the sliding window stillness detector: sequencer, ring and configuration.
//
// The block watches a moving body and reports when it has stood still over a time window.
// Input beats arrive on i_in; command START latches the position and clears the window,
// command UPDATE brings the elapsed time and a new position. Every input beat gives
// exactly one result beat on o_out: stopped, window_filled, window_distance (Q16.16 m)
// and window_time_us.
// An update passes through the step distance unit: the squares of dx and dy, 25 square
// root steps and 41 divide steps through one shared subtractor, and a done state. The
// sequencer then pushes, checks and outputs; a full ring first drops its oldest entry,
// and each entry aged out of the window takes an eviction and another check. A start
// beat goes straight from idle to the output state. i_in.ready is high only while the
// sequencer is idle.
// The result sits in an output register; the block takes the next input beat while it
// waits. If the receiver stalls, a finished item waits in the sequencer until the output
// register frees up. After reset (i_rst_n low at a clock edge) the sums, flag, ring
// pointers and last position are zero and the registers hold their defaults. The user
// must write configuration over the APB port only while the block is idle; the block does
// not enforce this. Ring entries are never read before written.
module sliding_window_stillness_detector import swsd_pkg::*; #(
    parameter int unsigned WINDOW_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    swsd_in_if.sink            i_in,
    swsd_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned IW = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(WINDOW_ENTRIES + 1);
    localparam int unsigned EW = DT_W + DIST_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ARITH  = 7'b0000010,
        S_FULLEV = 7'b0000100,
        S_PUSH   = 7'b0001000,
        S_CHK    = 7'b0010000,
        S_EV     = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state              r_state, n_state;

    // Configuration registers.
    logic [TWIN_W-1:0]   r_twin;
    logic [DIST_W-1:0]   r_dlim;
    logic [PPM_W-1:0]    r_ppm;
    t_reg_idx            cfg_idx;
    logic                cfg_wr;

    // Window state.
    logic [POS_W-1:0]    r_last_x, r_last_y;
    logic [TSUM_W-1:0]   r_tsum, n_tsum;
    logic [DIST_W-1:0]   r_dsum, n_dsum;
    logic                r_filled, n_filled;
    logic [IW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [DT_W-1:0]     r_dt;

    // Ring storage, read at the head every cycle.
    logic [EW-1:0]       r_ring [WINDOW_ENTRIES];
    logic [EW-1:0]       r_rd;
    logic [IW:0]         tail_sum;
    logic [IW-1:0]       tail;
    logic                ring_wr;

    // Eviction arithmetic on the oldest entry.
    logic [DT_W-1:0]     old_t;
    logic [DIST_W-1:0]   old_d;
    logic [TSUM_W-1:0]   ev_tsum;
    logic [DIST_W-1:0]   ev_dsum;
    logic [IW-1:0]       head_inc;
    logic [DIST_W:0]     add_d;

    // Step distance unit.
    logic                ar_start, ar_done;
    logic [DIST_W-1:0]   ar_dist;
    logic signed [DIFF_W-1:0] dx, dy;

    // Output register.
    logic                r_ov;
    logic                r_o_stop, r_o_fill;
    logic [DIST_W-1:0]   r_o_dist;
    logic [TWIN_W-1:0]   r_o_time;
    logic                out_free, in_acc;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_TIME_WINDOW: prdata = {8'b0, r_twin};
            REG_DIST_LIMIT:  prdata = r_dlim;
            REG_PIX_PER_M:   prdata = {16'b0, r_ppm};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twin <= TWIN_RESET;
            r_dlim <= DLIM_RESET;
            r_ppm  <= PPM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TIME_WINDOW: r_twin <= pwdata[TWIN_W-1:0];
                REG_DIST_LIMIT:  r_dlim <= pwdata[DIST_W-1:0];
                REG_PIX_PER_M:   r_ppm  <= pwdata[PPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side and step distance.
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign ar_start   = in_acc && (i_in.command == CMD_UPDATE);

    assign dx = {i_in.pos_x[POS_W-1], i_in.pos_x} - {r_last_x[POS_W-1], r_last_x};
    assign dy = {i_in.pos_y[POS_W-1], i_in.pos_y} - {r_last_y[POS_W-1], r_last_y};

    swsd_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ar_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .i_ppm   (r_ppm),
        .o_done  (ar_done),
        .o_dist  (ar_dist)
    );

    // ------------------------------------------------------------------
    // Ring addressing and eviction arithmetic.
    // ------------------------------------------------------------------
    assign tail_sum = {1'b0, r_head} + {1'b0, r_count[IW-1:0]};
    assign tail     = (tail_sum >= (IW+1)'(WINDOW_ENTRIES))
                      ? IW'(tail_sum - (IW+1)'(WINDOW_ENTRIES)) : tail_sum[IW-1:0];
    assign head_inc = (r_head == IW'(WINDOW_ENTRIES - 1)) ? '0 : r_head + IW'(1);

    assign old_t   = r_rd[EW-1:DIST_W];
    assign old_d   = r_rd[DIST_W-1:0];
    assign ev_tsum = (r_tsum >= TSUM_W'(old_t)) ? r_tsum - TSUM_W'(old_t) : '0;
    assign ev_dsum = (r_dsum >= old_d) ? r_dsum - old_d : '0;
    assign add_d   = {1'b0, r_dsum} + {1'b0, ar_dist};
    assign ring_wr = (r_state == S_PUSH);

    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[tail] <= {r_dt, ar_dist};
        end
        r_rd <= r_ring[r_head];
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_tsum   = r_tsum;
        n_dsum   = r_dsum;
        n_filled = r_filled;
        n_head   = r_head;
        n_count  = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.command == CMD_START) begin
                        n_tsum   = '0;
                        n_dsum   = '0;
                        n_filled = 1'b0;
                        n_head   = '0;
                        n_count  = '0;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_ARITH;
                    end
                end
            end
            S_ARITH: begin
                if (ar_done) begin
                    n_state = (r_count >= CW'(WINDOW_ENTRIES)) ? S_FULLEV : S_PUSH;
                end
            end
            S_FULLEV: begin
                // A full ring drops its oldest entry without marking the window filled.
                n_tsum  = ev_tsum;
                n_dsum  = ev_dsum;
                n_head  = head_inc;
                n_count = r_count - CW'(1);
                n_state = S_PUSH;
            end
            S_PUSH: begin
                n_tsum  = r_tsum + TSUM_W'(r_dt);
                n_dsum  = add_d[DIST_W] ? '1 : add_d[DIST_W-1:0];
                n_count = r_count + CW'(1);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_tsum > TSUM_W'(r_twin)) begin
                    if (r_count == '0) begin
                        n_tsum  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_EV;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_EV: begin
                n_tsum   = ev_tsum;
                n_dsum   = ev_dsum;
                n_head   = head_inc;
                n_count  = r_count - CW'(1);
                n_filled = 1'b1;
                n_state  = S_CHK;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tsum   <= '0;
            r_dsum   <= '0;
            r_filled <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
        end else begin
            r_state  <= n_state;
            r_tsum   <= n_tsum;
            r_dsum   <= n_dsum;
            r_filled <= n_filled;
            r_head   <= n_head;
            r_count  <= n_count;
            if (in_acc) begin
                r_last_x <= i_in.pos_x;
                r_last_y <= i_in.pos_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dt <= i_in.delta_time_us;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_stop <= r_filled && (r_dsum < r_dlim);
            r_o_fill <= r_filled;
            r_o_dist <= r_dsum;
            r_o_time <= r_tsum[TWIN_W-1:0];
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.stopped         = r_o_stop;
    assign o_out.window_filled   = r_o_fill;
    assign o_out.window_distance = r_o_dist;
    assign o_out.window_time_us  = r_o_time;

endmodule

### rtl/swsd_arith.sv
// Step distance unit: squares, digit-by-digit square root and restoring division.
module swsd_arith import swsd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    input  logic [PPM_W-1:0]         i_ppm,
    output logic                     o_done,
    output logic [DIST_W-1:0]        o_dist
);

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_SQX  = 6'b000010,
        A_SQY  = 6'b000100,
        A_SQRT = 6'b001000,
        A_DIV  = 6'b010000,
        A_DONE = 6'b100000
    } t_ar_state;

    t_ar_state          r_state, n_state;
    logic [DIFF_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]    r_val, n_val;
    logic [27:0]        r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [5:0]         r_cnt, n_cnt;

    logic [DIFF_W-1:0]  mul_op;
    logic [SQ_W-1:0]    mul_res;
    logic [27:0]        sub_a, sub_b, sub_diff;
    logic               sub_ge;
    logic [PPM_W-1:0]   ppm_eff;

    assign ppm_eff = (i_ppm == '0) ? PPM_ONE : i_ppm;

    // One multiplier, used for both squares.
    assign mul_op  = (r_state == A_SQX) ? r_ax : r_ay;
    assign mul_res = mul_op * mul_op;

    // One compare and subtract unit, shared by square root and division.
    always_comb begin
        if (r_state == A_SQRT) begin
            sub_a = {r_rem[25:0], r_val[SQ_W-1 -: 2]};
            sub_b = {1'b0, r_root, 2'b01};
        end else begin
            sub_a = {11'b0, r_rem[15:0], r_quo[QUO_W-1]};
            sub_b = {12'b0, ppm_eff};
        end
        sub_ge   = (sub_a >= sub_b);
        sub_diff = sub_a - sub_b;
    end

    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_rem   = r_rem;
        n_root  = r_root;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        unique case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    n_state = A_SQX;
                end
            end
            A_SQX: begin
                n_val   = mul_res;
                n_state = A_SQY;
            end
            A_SQY: begin
                n_val   = r_val + mul_res;
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = '0;
                n_state = A_SQRT;
            end
            A_SQRT: begin
                n_val = {r_val[SQ_W-3:0], 2'b00};
                if (sub_ge) begin
                    n_rem  = sub_diff;
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = sub_a;
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(ROOT_W - 1)) begin
                    n_quo   = {n_root, 16'b0};
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = A_DIV;
                end
            end
            A_DIV: begin
                n_quo = {r_quo[QUO_W-2:0], sub_ge};
                n_rem = sub_ge ? {11'b0, sub_diff[16:0]} : {11'b0, sub_a[16:0]};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(QUO_W - 1)) begin
                    n_state = A_DONE;
                end
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        if (r_state == A_IDLE && i_start) begin
            r_ax <= i_dx[DIFF_W-1] ? DIFF_W'(-i_dx) : DIFF_W'(i_dx);
            r_ay <= i_dy[DIFF_W-1] ? DIFF_W'(-i_dy) : DIFF_W'(i_dy);
        end
    end

    assign o_done = (r_state == A_DONE);
    assign o_dist = (r_quo[QUO_W-1:DIST_W] != '0) ? '1 : r_quo[DIST_W-1:0];

endmodule

### sim/tb.sv
// Testbench for the sliding window stillness detector: directed and random beats with a predictor.
module tb;
    import swsd_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    swsd_in_if  in_ch ();
    swsd_out_if out_ch ();

    sliding_window_stillness_detector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int RING_DEPTH = 64;
    localparam int IDLE_LIMIT = 200000;
    localparam int EXP_DEPTH  = 64;

    // Expected result of one beat.
    typedef struct packed {
        logic              stopped;
        logic              filled;
        logic [DIST_W-1:0] win_dist;
        logic [TWIN_W-1:0] tsum;
    } t_window_state;

    // Predictor state: a private copy of the configuration and the window.
    logic [TWIN_W-1:0] win_len;
    logic [DIST_W-1:0] dist_lim;
    logic [PPM_W-1:0]  ppm;
    logic signed [POS_W-1:0] prev_x, prev_y;
    logic [31:0] time_acc;
    logic [DIST_W-1:0] dist_acc;
    logic filled_now;
    logic [DT_W-1:0]   hist_time [RING_DEPTH];
    logic [DIST_W-1:0] hist_dist [RING_DEPTH];
    int head_idx, held;

    // Expected results in order, kept in a circular buffer.
    t_window_state exp_buf [EXP_DEPTH];
    int exp_wr, exp_rd;
    int mismatches, results_seen, beats_sent, idle_cycles;
    int send_idle_pct, recv_stall_pct;
    bit hold_recv;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic evict_oldest();
        time_acc = (time_acc >= hist_time[head_idx]) ? time_acc - hist_time[head_idx] : 0;
        dist_acc = (dist_acc >= hist_dist[head_idx]) ? dist_acc - hist_dist[head_idx] : 0;
        head_idx = (head_idx + 1) % RING_DEPTH;
        held--;
    endtask

    // Advance the window by one beat and return what the block must report.
    task automatic predict_window(input logic cmd, input logic [DT_W-1:0] dt,
                                  input logic signed [POS_W-1:0] x,
                                  input logic signed [POS_W-1:0] y,
                                  output t_window_state r);
        longint dx, dy;
        logic [63:0] len, step, divisor;
        logic [DIST_W-1:0] step32;
        r = '0;
        if (cmd == CMD_START) begin
            prev_x = x; prev_y = y;
            time_acc = 0; dist_acc = 0; filled_now = 1'b0; head_idx = 0; held = 0;
            return;
        end
        dx = longint'(x) - longint'(prev_x);
        dy = longint'(y) - longint'(prev_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        len = int_sqrt(64'(dx * dx + dy * dy));
        divisor = (ppm == 0) ? 64'd1 : 64'(ppm);
        step = (len << 16) / divisor;
        step32 = (step > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : step[31:0];
        if (held >= RING_DEPTH) evict_oldest();
        hist_time[(head_idx + held) % RING_DEPTH] = dt;
        hist_dist[(head_idx + held) % RING_DEPTH] = step32;
        held++;
        time_acc = time_acc + dt;
        dist_acc = (32'hFFFF_FFFF - dist_acc < step32) ? 32'hFFFF_FFFF : dist_acc + step32;
        prev_x = x; prev_y = y;
        // Age out entries; an empty ring with time left over just clears the sum.
        while (time_acc > win_len) begin
            if (held == 0) begin
                time_acc = 0;
                break;
            end
            evict_oldest();
            filled_now = 1'b1;
        end
        r.stopped = filled_now && (dist_acc < dist_lim);
        r.filled = filled_now;
        r.win_dist = dist_acc;
        r.tsum = time_acc[TWIN_W-1:0];
    endtask

    // Send one beat; the expectation is queued when the beat is accepted.
    // Valid stays high after the beat until the sender idles or drains.
    task automatic send_beat(input logic cmd, input logic [DT_W-1:0] dt,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y);
        t_window_state r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.delta_time_us <= dt;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_window(cmd, dt, x, y, r);
        exp_buf[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
        beats_sent++;
    endtask

    // Wait until every expected beat has come back, plus the block's tail latency.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx)); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_TIME_WINDOW: win_len = value[TWIN_W-1:0];
            REG_DIST_LIMIT:  dist_lim = value;
            REG_PIX_PER_M:   ppm = value[PPM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] w, input logic [31:0] d, input logic [31:0] p);
        drain();
        apb_write(REG_TIME_WINDOW, w);
        apb_write(REG_DIST_LIMIT, d);
        apb_write(REG_PIX_PER_M, p);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    // Directed corners: field extremes, both commands, saturation and the ring wrap.
    task automatic test_directed();
        send_beat(CMD_UPDATE, 20'd100, 24'sd0, 24'sd0);
        send_beat(CMD_START, '1, 24'sh7FFFFF, 24'sh800000);
        send_beat(CMD_UPDATE, '1, 24'sh800000, 24'sh7FFFFF);
        send_beat(CMD_UPDATE, 20'd0, 24'sh7FFFFF, 24'sh800000);
        send_beat(CMD_UPDATE, 20'd5, 24'sh7FFFFF, 24'sh800000);
        set_config(32'd1, 32'hFFFF_FFFF, 32'd1);
        send_beat(CMD_START, 20'd0, 24'sh800000, 24'sh800000);
        send_beat(CMD_UPDATE, 20'd1, 24'sh7FFFFF, 24'sh7FFFFF);
        send_beat(CMD_UPDATE, 20'd1, 24'sh800000, 24'sh800000);
        send_beat(CMD_UPDATE, 20'd2, 24'sh7FFFFF, 24'sh800000);
        // Zero window and zero scale: once any time has passed every entry ages out, and the scale acts as one.
        set_config(32'd0, 32'd0, 32'd0);
        send_beat(CMD_START, 20'd0, 24'sd0, 24'sd0);
        send_beat(CMD_UPDATE, 20'd0, 24'sd256, 24'sd0);
        send_beat(CMD_UPDATE, 20'd7, 24'sd0, 24'sd0);
        // Huge window: the ring overflows without setting the filled flag.
        set_config(32'hFF_FFFF, 32'd655, 32'hFFFF);
        send_beat(CMD_START, 20'd0, 24'sd0, 24'sd0);
        for (int i = 0; i < 70; i++) send_beat(CMD_UPDATE, 20'd1000, 24'(i), 24'(-i));
    endtask

    // Mostly plausible tracks with small steps, plus occasional jumps and restarts.
    task automatic test_random(input int count);
        logic signed [POS_W-1:0] x, y;
        x = 0; y = 0;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(19))
                0: begin
                    x = rand_pos(); y = rand_pos();
                    send_beat(CMD_START, DT_W'($urandom), x, y);
                end
                1, 2: begin
                    x = rand_pos(); y = rand_pos();
                    send_beat(CMD_UPDATE, DT_W'($urandom), x, y);
                end
                default: begin
                    x = x + POS_W'($urandom_range(64) - 32);
                    y = y + POS_W'($urandom_range(64) - 32);
                    send_beat(CMD_UPDATE, DT_W'($urandom_range(40000)), x, y);
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            test_random(20);
        join
        drain();
        test_random(10);
    endtask

    // Receiver side: random stalls and the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_window_state want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: got %0b %0b %h %0d",
                             out_ch.stopped, out_ch.window_filled,
                             out_ch.window_distance, out_ch.window_time_us);
            end else begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (out_ch.stopped !== want.stopped || out_ch.window_filled !== want.filled ||
                    out_ch.window_distance !== want.win_dist ||
                    out_ch.window_time_us !== want.tsum) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0b %0b %h %0d, got %0b %0b %h %0d",
                                 want.stopped, want.filled, want.win_dist, want.tsum,
                                 out_ch.stopped, out_ch.window_filled,
                                 out_ch.window_distance, out_ch.window_time_us);
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.command = 1'b0; in_ch.delta_time_us = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; results_seen = 0; beats_sent = 0; idle_cycles = 0;
        exp_wr = 0; exp_rd = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 1'b0;
        win_len = TWIN_RESET; dist_lim = DLIM_RESET; ppm = PPM_RESET;
        prev_x = 0; prev_y = 0; time_acc = 0; dist_acc = 0; filled_now = 0;
        head_idx = 0; held = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_config(32'd500000, 32'd655, 32'd8192);
        test_random(425);
        send_idle_pct = 55;
        set_config(32'd60000, 32'd20000, 32'd256);
        test_random(425);
        send_idle_pct = 0; recv_stall_pct = 55;
        set_config(32'd200000, 32'd5000, 32'd1);
        test_random(425);
        send_idle_pct = 20; recv_stall_pct = 20;
        set_config(32'd1000000, 32'd100000, 32'd65535);
        test_random(425);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_backpressure();
        drain();

        $display("Sent %0d beats over several configurations, idle mixes and a long stall;",
                 beats_sent);
        $display("checked %0d result beats, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && exp_wr == exp_rd) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
